>>> hw/rtl/acked_record_retransmit_buffer_core_assert.svh
// Assertion macros for the acked record retransmit buffer.
// Clocked on clk_i; the reset-qualified form also uses the active-low rst_ni.
`ifndef ACKED_RECORD_RETRANSMIT_BUFFER_CORE_ASSERT_SVH
`define ACKED_RECORD_RETRANSMIT_BUFFER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ARRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ARRB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");
`else
`define ARRB_ASSERT(lbl, prop)
`define ARRB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hw/rtl/arrb_pkg.sv
// Shared types and constants of the acked record retransmit buffer.
// No dependencies.
`default_nettype none

package arrb_pkg;

  localparam int unsigned DefaultDepth = 32;

  // Command codes of an input request.
  localparam logic [1:0] CmdAdd     = 2'd0;
  localparam logic [1:0] CmdAck     = 2'd1;
  localparam logic [1:0] CmdDump    = 2'd2;
  localparam logic [1:0] CmdSetTrip = 2'd3;

  // Configuration address: bit 2 selects the register, the timestamp floor is register 0.
  localparam int unsigned CfgAddrW   = 3;
  localparam logic        CfgMinTime = 1'b0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] timestamp;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [55:0] payload_high;
    logic [23:0] uptime_seconds;
    logic [31:0] round_trip_us;
  } in_req_t;

  typedef struct packed {
    logic [31:0] out_timestamp;
    logic [63:0] out_payload_low;
    logic [63:0] out_payload_mid;
    logic [55:0] out_payload_high;
    logic [23:0] out_uptime_seconds;
    logic [15:0] round_trip_16us;
    logic        last;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [63:0] pl_low;
    logic [63:0] pl_mid;
    logic [55:0] pl_high;
    logic [23:0] uptime;
    logic [15:0] trip;
  } record_t;

  typedef enum logic [1:0] {
    OpAdd,
    OpAck,
    OpDump
  } op_e;

  typedef struct packed {
    op_e     op;
    record_t rec;
  } work_t;

endpackage

`default_nettype wire

>>> hw/rtl/arrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/arrb_fifo.sv
// Two-entry queue built from flip-flops.
// No dependencies.
`default_nettype none

module arrb_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2];
  logic             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arrb_front.sv
// Front end: accepts requests, filters them and keeps the pending round trip.
// Depends on arrb_pkg.
`default_nettype none

module arrb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  arrb_pkg::in_req_t req_i,
  input  logic [31:0]       stamp_floor_i,
  input  logic              wq_full_i,
  output logic              wq_push_o,
  output arrb_pkg::work_t   wq_data_o
);
  import arrb_pkg::*;

  logic [31:0] pending_q, pending_d;
  logic        accept;
  logic [15:0] trip_units;

  assign full_o = wq_full_i;
  assign accept = push_i & ~wq_full_i;

  // Round trip in 16 us units; a quotient beyond 16 bits is stored as zero.
  assign trip_units = (pending_q[31:20] != 12'd0) ? 16'd0 : pending_q[19:4];

  always_comb begin
    pending_d              = pending_q;
    wq_push_o              = 1'b0;
    wq_data_o.op           = OpAdd;
    wq_data_o.rec.stamp    = req_i.timestamp;
    wq_data_o.rec.pl_low   = req_i.payload_low;
    wq_data_o.rec.pl_mid   = req_i.payload_mid;
    wq_data_o.rec.pl_high  = req_i.payload_high;
    wq_data_o.rec.uptime   = req_i.uptime_seconds;
    wq_data_o.rec.trip     = trip_units;
    if (accept) begin
      case (req_i.cmd)
        CmdAdd: begin
          if (req_i.timestamp > stamp_floor_i) begin
            wq_push_o = 1'b1;
            pending_d = 32'd0;
          end
        end
        CmdAck: begin
          wq_data_o.op = OpAck;
          wq_push_o    = (req_i.timestamp != 32'd0);
        end
        CmdDump: begin
          wq_data_o.op = OpDump;
          wq_push_o    = 1'b1;
        end
        CmdSetTrip: begin
          pending_d = req_i.round_trip_us;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 32'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/arrb_back.sv
// Back end: record store as a circular buffer in RAM, with search, erase and dump.
// Depends on arrb_pkg and arrb_ram.
`default_nettype none

module arrb_back #(
  parameter int unsigned Depth = arrb_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wq_empty_i,
  input  arrb_pkg::work_t    wq_data_i,
  output logic               wq_pop_o,
  input  logic               rsp_full_i,
  output logic               rsp_push_o,
  output arrb_pkg::out_rsp_t rsp_data_o,
  output logic               busy_o
);
  import arrb_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [CW:0] DepthW = (CW + 1)'(Depth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StSrd  = 3'd3;
  localparam logic [2:0] StSwr  = 3'd4;
  localparam logic [2:0] StDrd  = 3'd5;
  localparam logic [2:0] StDout = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [31:0]   ts_q, ts_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  record_t       wdata, rdata;
  logic [CW:0]   idx1, idx2, cnt_ext;

  // Physical slot of logical position off, counted from the oldest record.
  function automatic logic [AW-1:0] phys(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[AW-1:0];
  endfunction

  assign idx1    = (CW + 1)'(idx_q) + (CW + 1)'(1);
  assign idx2    = (CW + 1)'(idx_q) + (CW + 1)'(2);
  assign cnt_ext = (CW + 1)'(count_q);
  assign busy_o  = (state_q != StIdle);

  always_comb begin
    rsp_data_o.out_timestamp      = rdata.stamp;
    rsp_data_o.out_payload_low    = rdata.pl_low;
    rsp_data_o.out_payload_mid    = rdata.pl_mid;
    rsp_data_o.out_payload_high   = rdata.pl_high;
    rsp_data_o.out_uptime_seconds = rdata.uptime;
    rsp_data_o.round_trip_16us    = rdata.trip;
    rsp_data_o.last               = (idx1 == cnt_ext);
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    ts_d       = ts_q;
    wq_pop_o   = 1'b0;
    rsp_push_o = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = phys(head_q, count_q);
    wdata      = wq_data_i.rec;
    raddr      = phys(head_q, idx_q);
    case (state_q)
      StIdle: begin
        if (!wq_empty_i) begin
          wq_pop_o = 1'b1;
          case (wq_data_i.op)
            OpAdd: begin
              // When full, the new record overwrites the oldest one.
              we = 1'b1;
              if (cnt_ext == DepthW) begin
                head_d = phys(head_q, CW'(1));
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            OpAck: begin
              ts_d  = wq_data_i.rec.stamp;
              idx_d = '0;
              if (count_q != '0) begin
                state_d = StRd;
              end
            end
            OpDump: begin
              idx_d = '0;
              if (count_q != '0) begin
                state_d = StDrd;
              end
            end
            default: ;
          endcase
        end
      end
      StRd: begin
        re      = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        if (rdata.stamp == ts_q) begin
          if (idx_q == '0) begin
            head_d  = phys(head_q, CW'(1));
            count_d = count_q - CW'(1);
            state_d = StIdle;
          end else if (idx1 < cnt_ext) begin
            state_d = StSrd;
          end else begin
            count_d = count_q - CW'(1);
            state_d = StIdle;
          end
        end else if (idx1 == cnt_ext) begin
          state_d = StIdle;
        end else begin
          idx_d   = idx1[CW-1:0];
          state_d = StRd;
        end
      end
      StSrd: begin
        re      = 1'b1;
        raddr   = phys(head_q, idx1[CW-1:0]);
        state_d = StSwr;
      end
      StSwr: begin
        we    = 1'b1;
        waddr = phys(head_q, idx_q);
        wdata = rdata;
        idx_d = idx1[CW-1:0];
        if (idx2 < cnt_ext) begin
          state_d = StSrd;
        end else begin
          count_d = count_q - CW'(1);
          state_d = StIdle;
        end
      end
      StDrd: begin
        re      = 1'b1;
        state_d = StDout;
      end
      StDout: begin
        if (!rsp_full_i) begin
          rsp_push_o = 1'b1;
          if (idx1 == cnt_ext) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx1[CW-1:0];
            state_d = StDrd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
  end

  arrb_ram #(
    .Width ($bits(record_t)),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/acked_record_retransmit_buffer_core.sv
// Top level of the acked record retransmit buffer: config register and wiring.
// Depends on arrb_pkg, arrb_fifo, arrb_front, arrb_back and the assertion header.
//
// Usage. Requests enter on req_i with push/full and results leave on rsp_o
// with empty/pop, both as queues. A request is taken whenever push is high
// and full is low. An add request stores a record whose timestamp is above
// the timestamp floor register, an acknowledge request erases the oldest record
// with that timestamp, a dump request returns every stored record oldest first
// with last set on the final one, and a set request loads the pending round trip.
// The front end takes one request per cycle while its two-entry work queue
// has room; set requests and filtered requests finish in the front end.
// The back end runs one work item at a time against a record RAM with one write
// and one read port: an add writes its record from the idle state, a dump reads
// and then sends each stored record, and an acknowledge reads and checks each
// record searched, then reads and rewrites each later record to close the gap
// (none when the oldest or newest record matches). When the receiver stops
// popping, the two-entry result queue fills, the back end waits, the work queue
// fills and full rises; nothing is lost. Reset empties the buffer, clears the
// pending round trip and the timestamp floor, and needs no clearing pass.
`default_nettype none
`include "acked_record_retransmit_buffer_core_assert.svh"

module acked_record_retransmit_buffer_core #(
  parameter int unsigned Depth = arrb_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request queue side.
  input  logic                             push,
  output logic                             full,
  input  arrb_pkg::in_req_t                req_i,
  // Result queue side.
  output logic                             empty,
  input  logic                             pop,
  output arrb_pkg::out_rsp_t               rsp_o,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [arrb_pkg::CfgAddrW-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import arrb_pkg::*;

  logic [31:0] stamp_floor_q;
  logic        cfg_write;

  logic        wq_push, wq_full, wq_pop, wq_empty;
  work_t       wq_wdata, wq_rdata;
  logic        rsp_push, rsp_full, back_busy;
  out_rsp_t    rsp_wdata;

  // The configuration port never stalls. Writes land at the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[CfgAddrW-1] == CfgMinTime) ? stamp_floor_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_floor_q <= 32'd0;
    end else if (cfg_write && (paddr[CfgAddrW-1] == CfgMinTime)) begin
      stamp_floor_q <= pwdata;
    end
  end

  // The front end filters requests and forwards real work to the back end.
  arrb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_i         (req_i),
    .stamp_floor_i (stamp_floor_q),
    .wq_full_i     (wq_full),
    .wq_push_o     (wq_push),
    .wq_data_o     (wq_wdata)
  );

  // The work queue lets the front keep taking requests during a long search.
  arrb_fifo #(
    .Width ($bits(work_t))
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .full_o  (wq_full),
    .wdata_i (wq_wdata),
    .pop_i   (wq_pop),
    .empty_o (wq_empty),
    .rdata_o (wq_rdata)
  );

  arrb_back #(
    .Depth (Depth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wq_empty_i (wq_empty),
    .wq_data_i  (wq_rdata),
    .wq_pop_o   (wq_pop),
    .rsp_full_i (rsp_full),
    .rsp_push_o (rsp_push),
    .rsp_data_o (rsp_wdata),
    .busy_o     (back_busy)
  );

  // The result queue decouples dump output from the receiver.
  arrb_fifo #(
    .Width ($bits(out_rsp_t))
  ) u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .full_o  (rsp_full),
    .wdata_i (rsp_wdata),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rsp_o)
  );

  // A result written into the result queue is visible on the next cycle.
  `ARRB_ASSERT(a_rsp_visible, (rsp_push && !rsp_full) |=> !empty)
  // An idle back end with no queued work never produces a result.
  `ARRB_ASSERT_ALWAYS(a_no_spurious_rsp, (!back_busy && wq_empty) |-> !rsp_push)
  // A stalled request must not reach the work queue.
  `ARRB_ASSERT(a_stall_no_work, (push && full) |-> !wq_push)

endmodule

`default_nettype wire
